/* hw/rtl/bvs_pkg.sv */
// ----------------------------------------------------------------------------
// bvs_pkg: shared types for the bounded vector store
// Opcodes, status codes, config indices, sequencer states and the command and result items.
// ----------------------------------------------------------------------------
package bvs_pkg;

  localparam int POS_BITS   = 8;
  localparam int FIELD_BITS = 32;
  localparam int CNT_BITS   = 5;

  typedef enum logic [2:0] {
    OP_PUSH      = 3'd0,
    OP_POP       = 3'd1,
    OP_READ_AT   = 3'd2,
    OP_WRITE_AT  = 3'd3,
    OP_RESIZE    = 3'd4,
    OP_CLEAR     = 3'd5,
    OP_FIND      = 3'd6,
    OP_READ_BACK = 3'd7
  } opcode_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic {
    CFG_CAPACITY = 1'b0,
    CFG_FILL     = 1'b1
  } cfg_index_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_FILL,
    S_SEARCH,
    S_DONE
  } state_t;

  typedef struct packed {
    opcode_t                opcode;
    logic [POS_BITS-1:0]    position;
    logic [FIELD_BITS-1:0]  word_in;
  } cmd_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0]  word_out;
    status_t                status;
    logic [POS_BITS-1:0]    found_position;
    logic [CNT_BITS-1:0]    count_now;
    logic                   is_full;
    logic                   is_empty;
  } result_t;

endpackage

/* hw/rtl/bounded_vector_store.sv */
// ----------------------------------------------------------------------------
// bounded_vector_store: fixed-capacity word vector with a fill count
// Push, pop, indexed read/write, resize, clear, find and read back.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive cmd and raise start; the item is taken at the
//   clock edge where start is high and busy is low. busy stays high until
//   the result has been shown.
//   Result channel: result is valid for exactly one cycle while done is
//   high. The receiver cannot stall; it must take the item in that cycle.
//   Config channel: cfg_valid/cfg_ready with cfg_index (0 capacity in use,
//   1 fill word) and cfg_data; write only while the block is idle.
// Sequence (start accept to done):
//   push, pop, clear, resize down, write inside the count: exec, then done.
//   read at, read back: exec, read, then done (registered memory read).
//   resize or write past the count: exec, then fill for the slots grown,
//   one memory write per cycle through the write port, then done.
//   find: exec, then search up to the first match or the last entry, then
//   done; the single read port feeds one compare per cycle.
//   A new command may start the cycle after done.
// Reset: count goes to zero, capacity to 16, fill word to zero. Storage is
//   not cleared; only entries below the count are ever read.
// ----------------------------------------------------------------------------
module bounded_vector_store #(
  parameter int DEPTH     = 16,
  parameter int WORD_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  bvs_pkg::cmd_t      cmd,
  output logic               done,
  output bvs_pkg::result_t   result,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  bvs_pkg::cfg_index_t cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  // common width for comparing position, count and capacity
  localparam int XW = (CW > bvs_pkg::POS_BITS) ? CW : bvs_pkg::POS_BITS;

  bvs_pkg::state_t state, state_next;
  bvs_pkg::cmd_t   cmd_q;

  logic [CW-1:0] count, count_next;
  logic [CW-1:0] ptr, ptr_next;
  logic [CW-1:0] fill_end, fill_end_next;
  logic [4:0]    capacity;
  logic [31:0]   fill_word;

  logic [31:0]                       res_word, res_word_next;
  bvs_pkg::status_t                  res_status, res_status_next;
  logic [bvs_pkg::POS_BITS-1:0]      res_found, res_found_next;

  // storage: one write port, one registered read port
  logic [WORD_BITS-1:0] mem [DEPTH];
  logic [WORD_BITS-1:0] rdata;
  logic                 we, re;
  logic [AW-1:0]        waddr, raddr;
  logic [WORD_BITS-1:0] wdata;

  // word views at the stored width
  logic [63:0]          key64, fill64, rd64;
  logic [WORD_BITS-1:0] key_w, fill_w;

  logic [XW-1:0] pos_x, cnt_x, cap_x, ptr_x;
  logic [CW-1:0] cnt_dec;
  logic full_f, empty_f, pos_lt_cnt, pos_ge_cap, pos_gt_cap, pos_eq_cnt, pos_zero;
  logic match, last;

  function automatic logic [AW-1:0] ptr_next_addr(input logic [CW-1:0] p);
    logic [CW-1:0] n;
    n = p + 1'b1;
    return n[AW-1:0];
  endfunction

  assign key64  = 64'(cmd_q.word_in);
  assign fill64 = 64'(fill_word);
  assign rd64   = 64'(rdata);
  assign key_w  = key64[WORD_BITS-1:0];
  assign fill_w = fill64[WORD_BITS-1:0];

  // capacity clamped to 1..DEPTH
  always_comb begin
    if (capacity == 5'd0) begin
      cap_x = XW'(1);
    end else if (XW'(capacity) > XW'(DEPTH)) begin
      cap_x = XW'(DEPTH);
    end else begin
      cap_x = XW'(capacity);
    end
  end

  assign pos_x   = XW'(cmd_q.position);
  assign cnt_x   = XW'(count);
  assign ptr_x   = XW'(ptr);
  assign cnt_dec = count - 1'b1;

  assign full_f     = (cnt_x >= cap_x);
  assign empty_f    = (count == '0);
  assign pos_lt_cnt = (pos_x < cnt_x);
  assign pos_ge_cap = (pos_x >= cap_x);
  assign pos_gt_cap = (pos_x > cap_x);
  assign pos_eq_cnt = (pos_x == cnt_x);
  assign pos_zero   = (cmd_q.position == '0);
  assign match      = (rdata == key_w);
  assign last       = ((ptr_x + 1'b1) == cnt_x);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      bvs_pkg::S_IDLE: begin
        if (start) state_next = bvs_pkg::S_EXEC;
      end
      bvs_pkg::S_EXEC: begin
        state_next = bvs_pkg::S_DONE;
        case (cmd_q.opcode)
          bvs_pkg::OP_READ_AT: begin
            if (pos_lt_cnt) state_next = bvs_pkg::S_READ;
          end
          bvs_pkg::OP_READ_BACK: begin
            if (!empty_f) state_next = bvs_pkg::S_READ;
          end
          bvs_pkg::OP_WRITE_AT: begin
            if (!pos_ge_cap && !pos_lt_cnt) state_next = bvs_pkg::S_FILL;
          end
          bvs_pkg::OP_RESIZE: begin
            if (!pos_eq_cnt && !pos_zero && !pos_gt_cap && !pos_lt_cnt) begin
              state_next = bvs_pkg::S_FILL;
            end
          end
          bvs_pkg::OP_FIND: begin
            if (!empty_f) state_next = bvs_pkg::S_SEARCH;
          end
          default: state_next = bvs_pkg::S_DONE;
        endcase
      end
      bvs_pkg::S_READ: state_next = bvs_pkg::S_DONE;
      bvs_pkg::S_FILL: begin
        if (ptr == fill_end) state_next = bvs_pkg::S_DONE;
      end
      bvs_pkg::S_SEARCH: begin
        if (match || last) state_next = bvs_pkg::S_DONE;
      end
      bvs_pkg::S_DONE: state_next = bvs_pkg::S_IDLE;
      default: state_next = bvs_pkg::S_IDLE;
    endcase
  end

  // memory control and datapath next values
  always_comb begin
    we              = 1'b0;
    waddr           = '0;
    wdata           = key_w;
    re              = 1'b0;
    raddr           = '0;
    count_next      = count;
    ptr_next        = ptr;
    fill_end_next   = fill_end;
    res_word_next   = res_word;
    res_status_next = res_status;
    res_found_next  = res_found;
    case (state)
      bvs_pkg::S_EXEC: begin
        res_word_next   = '0;
        res_status_next = bvs_pkg::ST_DONE;
        res_found_next  = '0;
        case (cmd_q.opcode)
          bvs_pkg::OP_PUSH: begin
            if (full_f) begin
              res_status_next = bvs_pkg::ST_FULL;
            end else begin
              we         = 1'b1;
              waddr      = count[AW-1:0];
              count_next = count + 1'b1;
            end
          end
          bvs_pkg::OP_POP: begin
            if (empty_f) res_status_next = bvs_pkg::ST_EMPTY;
            else count_next = cnt_dec;
          end
          bvs_pkg::OP_READ_AT: begin
            if (!pos_lt_cnt) begin
              res_status_next = bvs_pkg::ST_EMPTY;
            end else begin
              re    = 1'b1;
              raddr = pos_x[AW-1:0];
            end
          end
          bvs_pkg::OP_WRITE_AT: begin
            if (pos_ge_cap) begin
              res_status_next = bvs_pkg::ST_FULL;
            end else if (pos_lt_cnt) begin
              we    = 1'b1;
              waddr = pos_x[AW-1:0];
            end else begin
              ptr_next      = count;
              fill_end_next = pos_x[CW-1:0];
            end
          end
          bvs_pkg::OP_RESIZE: begin
            if (pos_eq_cnt) begin
              count_next = count;
            end else if (pos_zero) begin
              count_next = '0;
            end else if (pos_gt_cap) begin
              res_status_next = bvs_pkg::ST_FULL;
            end else if (pos_lt_cnt) begin
              count_next = pos_x[CW-1:0];
            end else begin
              ptr_next      = count;
              fill_end_next = pos_x[CW-1:0];
            end
          end
          bvs_pkg::OP_CLEAR: count_next = '0;
          bvs_pkg::OP_FIND: begin
            res_status_next = bvs_pkg::ST_NOT_FOUND;
            ptr_next        = '0;
            re              = !empty_f;
          end
          default: begin
            if (empty_f) begin
              res_status_next = bvs_pkg::ST_EMPTY;
            end else begin
              re    = 1'b1;
              raddr = cnt_dec[AW-1:0];
            end
          end
        endcase
      end
      bvs_pkg::S_READ: res_word_next = rd64[31:0];
      bvs_pkg::S_FILL: begin
        if (ptr == fill_end) begin
          // write-at lands its word in the last slot; resize just commits
          if (cmd_q.opcode == bvs_pkg::OP_WRITE_AT) begin
            we         = 1'b1;
            waddr      = ptr[AW-1:0];
            count_next = fill_end + 1'b1;
          end else begin
            count_next = fill_end;
          end
        end else begin
          we       = 1'b1;
          waddr    = ptr[AW-1:0];
          wdata    = fill_w;
          ptr_next = ptr + 1'b1;
        end
      end
      bvs_pkg::S_SEARCH: begin
        // rdata holds entry ptr, read in the previous cycle
        if (match) begin
          res_status_next = bvs_pkg::ST_DONE;
          res_found_next  = ptr_x[bvs_pkg::POS_BITS-1:0];
        end else if (!last) begin
          re       = 1'b1;
          raddr    = ptr_next_addr(ptr);
          ptr_next = ptr + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bvs_pkg::S_IDLE;
      count     <= '0;
      capacity  <= 5'd16;
      fill_word <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          bvs_pkg::CFG_CAPACITY: capacity  <= cfg_data[4:0];
          bvs_pkg::CFG_FILL:     fill_word <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == bvs_pkg::S_IDLE && start) cmd_q <= cmd;
    ptr        <= ptr_next;
    fill_end   <= fill_end_next;
    res_word   <= res_word_next;
    res_status <= res_status_next;
    res_found  <= res_found_next;
  end

  assign busy      = (state != bvs_pkg::S_IDLE);
  assign done      = (state == bvs_pkg::S_DONE);
  assign cfg_ready = !busy;

  // flags come straight from the committed count
  always_comb begin
    result.word_out       = res_word;
    result.status         = res_status;
    result.found_position = res_found;
    result.count_now      = cnt_x[bvs_pkg::CNT_BITS-1:0];
    result.is_full        = full_f;
    result.is_empty       = empty_f;
  end

  // count never passes the built depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    XW'(count) <= XW'(DEPTH))
    else $error("entry count beyond depth");

  // an accepted command keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("command accepted but block not busy");

  // a result is shown for one cycle, then the block is free
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> (!done && !busy))
    else $error("done not a single-cycle pulse");

  // a search never runs with an empty vector
  a_search_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == bvs_pkg::S_SEARCH) |-> (count != '0))
    else $error("search on empty vector");

endmodule
